[src/xbr_pkg.sv]
`default_nettype none

package xbr_pkg;

	localparam int BLOCK_BYTES_DEF = 128;
	localparam int DATA_W = 8;
	localparam int INDEX_W = 7;
	localparam int VERDICT_W = 2;
	localparam int FINISH_W = 3;
	localparam int CRC_W = 16;

	localparam logic [DATA_W-1:0] CH_SOH = 8'h01;
	localparam logic [DATA_W-1:0] CH_EOT = 8'h04;
	localparam logic [DATA_W-1:0] CH_ACK = 8'h06;
	localparam logic [DATA_W-1:0] CH_NAK = 8'h15;
	localparam logic [DATA_W-1:0] CH_CAN = 8'h18;
	localparam logic [DATA_W-1:0] CH_C = 8'h43;

	localparam logic [DATA_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [DATA_W:0] NUMBER_PAIR_SUM = 9'd255;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic USE_CRC_RESET = 1'b1;
	localparam logic [DATA_W-1:0] ERROR_LIMIT_RESET = 8'd10;

	localparam logic REG_USE_CRC = 1'b0;
	localparam logic REG_ERROR_LIMIT = 1'b1;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_BYTE = 1'b1;

	localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_COMMIT = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_DISCARD = 2'd2;

	localparam logic [FINISH_W-1:0] FIN_RUNNING = 3'd0;
	localparam logic [FINISH_W-1:0] FIN_DONE = 3'd1;
	localparam logic [FINISH_W-1:0] FIN_CANCELLED = 3'd2;
	localparam logic [FINISH_W-1:0] FIN_EXCESS = 3'd3;
	localparam logic [FINISH_W-1:0] FIN_UNKNOWN = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WAIT   = 5'b00010,
		ST_BLOCK  = 5'b00100,
		ST_EOT1   = 5'b01000,
		ST_HALTED = 5'b10000
	} state_t;

	typedef struct packed {
		logic use_crc;
		logic [DATA_W-1:0] error_limit;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic [DATA_W-1:0] rx_byte;
		logic is_soh;
		logic is_eot;
		logic is_can;
	} item_t;

	typedef struct packed {
		logic reply_valid;
		logic [DATA_W-1:0] reply_byte;
		logic send_cancel;
		logic data_valid;
		logic [DATA_W-1:0] data_byte;
		logic [INDEX_W-1:0] data_index;
		logic [VERDICT_W-1:0] block_verdict;
		logic [FINISH_W-1:0] finished;
	} result_t;

	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
		input logic [DATA_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {b, {(CRC_W-DATA_W){1'b0}}};
		for (int i = 0; i < DATA_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[src/xmodem_block_receiver.sv]
// Path: the front queue holds an item; the engine turns it into a result that the result queue holds.
// Throughput: one item per cycle; the protocol engine retires one item in each cycle
// in which the front queue holds an item and the two-entry result queue has room.
// Reset: arst_n clears both queues, the protocol state (idle) and the registers to
// use_crc = 1 and error_limit = 10; there is no clearing pass.
`default_nettype none

module xmodem_block_receiver
	import xbr_pkg::*;
#(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 func,
	input  wire logic [DATA_W-1:0]    rx_byte,
	output logic                      empty,
	input  wire logic                 pop,
	output logic                      reply_valid,
	output logic [DATA_W-1:0]         reply_byte,
	output logic                      send_cancel,
	output logic                      data_valid,
	output logic [DATA_W-1:0]         data_byte,
	output logic [INDEX_W-1:0]        data_index,
	output logic [VERDICT_W-1:0]      block_verdict,
	output logic [FINISH_W-1:0]       finished,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	cfg_t cfg_q;
	item_t item;
	logic item_empty;
	logic item_pop;
	logic res_full;
	logic res_push;
	result_t res;
	logic [$bits(result_t)-1:0] out_rdata;
	result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_crc <= USE_CRC_RESET;
			cfg_q.error_limit <= ERROR_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USE_CRC: cfg_q.use_crc <= cfg_data[0];
				REG_ERROR_LIMIT: cfg_q.error_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	xbr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.func(func),
		.rx_byte(rx_byte),
		.full(full),
		.item_pop(item_pop),
		.item(item),
		.item_empty(item_empty)
	);

	xbr_engine #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(item),
		.item_empty(item_empty),
		.item_pop(item_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res)
	);

	xbr_fifo #(
		.WIDTH($bits(result_t))
	) u_result_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(res_full),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty)
	);

	assign out_res = result_t'(out_rdata);
	assign reply_valid = out_res.reply_valid;
	assign reply_byte = out_res.reply_byte;
	assign send_cancel = out_res.send_cancel;
	assign data_valid = out_res.data_valid;
	assign data_byte = out_res.data_byte;
	assign data_index = out_res.data_index;
	assign block_verdict = out_res.block_verdict;
	assign finished = out_res.finished;

endmodule

`default_nettype wire

[src/xbr_fifo.sv]
`default_nettype none

module xbr_fifo
	import xbr_pkg::*;
#(
	parameter int WIDTH = DATA_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	logic [1:0] count_q;
	logic [WIDTH-1:0] slot0_q;
	logic [WIDTH-1:0] slot1_q;
	logic wr;
	logic rd;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign wr = push && !full;
	assign rd = pop && !empty;
	assign rdata = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr && ((count_q == 2'd0) || (count_q == 2'd1 && rd))) begin
			slot0_q <= wdata;
		end else if (rd && count_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
		if (wr && count_q == 2'd1 && !rd) begin
			slot1_q <= wdata;
		end
	end

endmodule

`default_nettype wire

[src/xbr_front.sv]
`default_nettype none

module xbr_front
	import xbr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              func,
	input  wire logic [DATA_W-1:0] rx_byte,
	output logic                   full,
	input  wire logic              item_pop,
	output item_t                  item,
	output logic                   item_empty
);

	item_t in_item;
	logic [$bits(item_t)-1:0] q_rdata;

	always_comb begin
		in_item.func = func;
		in_item.rx_byte = rx_byte;
		in_item.is_soh = (rx_byte == CH_SOH);
		in_item.is_eot = (rx_byte == CH_EOT);
		in_item.is_can = (rx_byte == CH_CAN);
	end

	xbr_fifo #(
		.WIDTH($bits(item_t))
	) u_item_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(in_item),
		.full(full),
		.pop(item_pop),
		.rdata(q_rdata),
		.empty(item_empty)
	);

	assign item = item_t'(q_rdata);

endmodule

`default_nettype wire

[src/xbr_engine.sv]
`default_nettype none

module xbr_engine
	import xbr_pkg::*;
#(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  item_empty,
	output logic       item_pop,
	input  wire logic  res_full,
	output logic       res_push,
	output result_t    res
);

	localparam int POS_W = $clog2(BLOCK_BYTES + 4);
	localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(BLOCK_BYTES + 2);

	state_t state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [DATA_W-1:0] last_good_q, last_good_d;
	logic [DATA_W-1:0] number_q, number_d;
	logic [DATA_W-1:0] compl_q, compl_d;
	logic [DATA_W-1:0] sum_q, sum_d;
	logic [CRC_W-1:0] crc_q, crc_d;
	logic [DATA_W-1:0] check_hi_q, check_hi_d;
	logic [DATA_W-1:0] err_cnt_q, err_cnt_d;
	logic at_end;
	logic check_ok;
	logic [POS_W-1:0] idx_full;

	assign item_pop = !item_empty && !res_full;
	assign res_push = item_pop;
	assign idx_full = pos_q - POS_W'(2);

	always_comb begin
		state_d = state_q;
		pos_d = pos_q;
		last_good_d = last_good_q;
		number_d = number_q;
		compl_d = compl_q;
		sum_d = sum_q;
		crc_d = crc_q;
		check_hi_d = check_hi_q;
		err_cnt_d = err_cnt_q;
		at_end = 1'b0;
		check_ok = 1'b0;
		res = '0;

		if (item.func == FUNC_START) begin
			state_d = ST_WAIT;
			pos_d = '0;
			last_good_d = '0;
			number_d = '0;
			compl_d = '0;
			sum_d = '0;
			crc_d = '0;
			check_hi_d = '0;
			err_cnt_d = '0;
			res.reply_valid = 1'b1;
			res.reply_byte = cfg.use_crc ? CH_C : CH_NAK;
		end else begin
			unique case (state_q)
				ST_WAIT: begin
					if (item.is_eot) begin
						res.reply_valid = 1'b1;
						res.reply_byte = CH_NAK;
						state_d = ST_EOT1;
					end else if (item.is_can) begin
						res.send_cancel = 1'b1;
						res.finished = FIN_CANCELLED;
						state_d = ST_HALTED;
					end else if (item.is_soh) begin
						state_d = ST_BLOCK;
						pos_d = '0;
						sum_d = '0;
						crc_d = '0;
					end else begin
						state_d = ST_HALTED;
						if (err_cnt_q > cfg.error_limit) begin
							res.send_cancel = 1'b1;
							res.finished = FIN_EXCESS;
						end else begin
							res.finished = FIN_UNKNOWN;
						end
					end
				end
				ST_EOT1: begin
					if (item.is_eot) begin
						res.reply_valid = 1'b1;
						res.reply_byte = CH_ACK;
						res.finished = FIN_DONE;
						state_d = ST_HALTED;
					end
				end
				ST_BLOCK: begin
					if (pos_q == POS_W'(0)) begin
						number_d = item.rx_byte;
					end else if (pos_q == POS_W'(1)) begin
						compl_d = item.rx_byte;
					end else if (pos_q < POS_DATA_END) begin
						res.data_valid = 1'b1;
						res.data_byte = item.rx_byte;
						res.data_index = idx_full[INDEX_W-1:0];
						sum_d = sum_q + item.rx_byte;
						crc_d = crc16_byte(crc_q, item.rx_byte);
					end else if (!cfg.use_crc) begin
						at_end = 1'b1;
						check_ok = (item.rx_byte == sum_q);
					end else if (pos_q == POS_DATA_END) begin
						check_hi_d = item.rx_byte;
					end else begin
						at_end = 1'b1;
						check_ok = ({check_hi_q, item.rx_byte} == crc_q);
					end

					if (!at_end) begin
						pos_d = pos_q + POS_W'(1);
					end else begin
						res.block_verdict = VERDICT_DISCARD;
						pos_d = '0;
						state_d = ST_WAIT;
						if (({1'b0, number_q} + {1'b0, compl_q}) != NUMBER_PAIR_SUM) begin
							res.reply_valid = 1'b1;
							res.reply_byte = CH_NAK;
							if (err_cnt_q != COUNT_MAX) begin
								err_cnt_d = err_cnt_q + 8'd1;
							end
						end else if (number_q == last_good_q) begin
							res.reply_valid = 1'b1;
							res.reply_byte = CH_ACK;
						end else if (number_q == last_good_q + 8'd1) begin
							res.reply_valid = 1'b1;
							if (check_ok) begin
								res.reply_byte = CH_ACK;
								res.block_verdict = VERDICT_COMMIT;
								last_good_d = last_good_q + 8'd1;
							end else begin
								res.reply_byte = CH_NAK;
								if (err_cnt_q != COUNT_MAX) begin
									err_cnt_d = err_cnt_q + 8'd1;
								end
							end
						end else begin
							state_d = ST_HALTED;
							if (err_cnt_q > cfg.error_limit) begin
								res.send_cancel = 1'b1;
								res.finished = FIN_EXCESS;
							end else begin
								res.finished = FIN_UNKNOWN;
							end
						end
					end
				end
				ST_IDLE, ST_HALTED: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			last_good_q <= '0;
			number_q <= '0;
			compl_q <= '0;
			sum_q <= '0;
			crc_q <= '0;
			check_hi_q <= '0;
			err_cnt_q <= '0;
		end else if (item_pop) begin
			state_q <= state_d;
			pos_q <= pos_d;
			last_good_q <= last_good_d;
			number_q <= number_d;
			compl_q <= compl_d;
			sum_q <= sum_d;
			crc_q <= crc_d;
			check_hi_q <= check_hi_d;
			err_cnt_q <= err_cnt_d;
		end
	end

	// A transaction that ends the transfer leaves the engine halted.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.finished != FIN_RUNNING |=> state_q == ST_HALTED)
		else $error("transfer ended without halting");

	// Outside a start, the error count never falls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(item_pop && item.func == FUNC_START) |=> err_cnt_q >= $past(err_cnt_q))
		else $error("error count fell without a start");

	// The byte position stays inside a framed block.
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_DATA_END + POS_W'(1))
		else $error("byte position beyond block trailer");

	// Tentative payload only comes out while a block is being received.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.data_valid |-> state_q == ST_BLOCK && item.func == FUNC_BYTE)
		else $error("payload byte outside a block");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import xbr_pkg::*;

	localparam int BLOCK_LEN = BLOCK_BYTES_DEF;
	localparam int PHASE_ITEMS = 140;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic func;
		logic [DATA_W-1:0] b;
	} link_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic func = FUNC_BYTE;
	logic [DATA_W-1:0] rx_byte = '0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_USE_CRC;
	logic [DATA_W-1:0] cfg_data = '0;
	logic full, empty;
	logic reply_valid, send_cancel, data_valid;
	logic [DATA_W-1:0] reply_byte, data_byte;
	logic [INDEX_W-1:0] data_index;
	logic [VERDICT_W-1:0] block_verdict;
	logic [FINISH_W-1:0] finished;

	xmodem_block_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .func(func), .rx_byte(rx_byte),
		.empty(empty), .pop(pop),
		.reply_valid(reply_valid), .reply_byte(reply_byte), .send_cancel(send_cancel),
		.data_valid(data_valid), .data_byte(data_byte), .data_index(data_index),
		.block_verdict(block_verdict), .finished(finished),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	link_item_t link_items[$];
	result_t responses_due[$];
	int items_queued, items_sent, results_seen, mismatches, transfers;
	int commits, discards;
	int endings [8];
	int idle_pct, stall_pct;
	logic hold = 1'b0;
	int cycles;

	// Receiver model state and its copy of the configuration registers.
	logic crc_mode = USE_CRC_RESET;
	logic [DATA_W-1:0] err_limit = ERROR_LIMIT_RESET;
	state_t link_phase = ST_IDLE;
	logic [DATA_W-1:0] pos_in_block = '0;
	logic [DATA_W-1:0] last_committed = '0;
	logic [DATA_W-1:0] hdr_number = '0;
	logic [DATA_W-1:0] hdr_complement = '0;
	logic [DATA_W-1:0] sum_acc = '0;
	logic [CRC_W-1:0] crc_acc = '0;
	logic [DATA_W-1:0] check_hi = '0;
	logic [DATA_W-1:0] errors_seen = '0;

	function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] c,
		input logic [DATA_W-1:0] b);
		logic [CRC_W-1:0] x;
		x = c;
		for (int k = DATA_W - 1; k >= 0; k--) begin
			if (x[CRC_W-1] ^ b[k]) begin
				x = {x[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				x = {x[CRC_W-2:0], 1'b0};
			end
		end
		return x;
	endfunction

	function automatic result_t abort_transfer(input result_t r);
		result_t o;
		o = r;
		link_phase = ST_HALTED;
		if (errors_seen > err_limit) begin
			o.send_cancel = 1'b1;
			o.finished = FIN_EXCESS;
		end else begin
			o.finished = FIN_UNKNOWN;
		end
		return o;
	endfunction

	function automatic result_t predict_response(input logic f, input logic [DATA_W-1:0] b);
		result_t r;
		logic at_end, check_ok;
		int at;
		r = '0;
		at_end = 1'b0;
		check_ok = 1'b0;
		at = int'(pos_in_block);
		if (f == FUNC_START) begin
			link_phase = ST_WAIT;
			pos_in_block = '0;
			last_committed = '0;
			hdr_number = '0;
			hdr_complement = '0;
			sum_acc = '0;
			crc_acc = '0;
			check_hi = '0;
			errors_seen = '0;
			r.reply_valid = 1'b1;
			r.reply_byte = crc_mode ? CH_C : CH_NAK;
		end else begin
			case (link_phase)
				ST_WAIT: begin
					if (b == CH_EOT) begin
						r.reply_valid = 1'b1;
						r.reply_byte = CH_NAK;
						link_phase = ST_EOT1;
					end else if (b == CH_CAN) begin
						r.send_cancel = 1'b1;
						r.finished = FIN_CANCELLED;
						link_phase = ST_HALTED;
					end else if (b == CH_SOH) begin
						link_phase = ST_BLOCK;
						pos_in_block = '0;
						sum_acc = '0;
						crc_acc = '0;
					end else begin
						r = abort_transfer(r);
					end
				end
				ST_EOT1: begin
					if (b == CH_EOT) begin
						r.reply_valid = 1'b1;
						r.reply_byte = CH_ACK;
						r.finished = FIN_DONE;
						link_phase = ST_HALTED;
					end
				end
				ST_BLOCK: begin
					if (at == 0) begin
						hdr_number = b;
					end else if (at == 1) begin
						hdr_complement = b;
					end else if (at < BLOCK_LEN + 2) begin
						r.data_valid = 1'b1;
						r.data_byte = b;
						r.data_index = INDEX_W'(at - 2);
						sum_acc = sum_acc + b;
						crc_acc = crc16_next(crc_acc, b);
					end else if (!crc_mode) begin
						at_end = 1'b1;
						check_ok = (b == sum_acc);
					end else if (at == BLOCK_LEN + 2) begin
						check_hi = b;
					end else begin
						at_end = 1'b1;
						check_ok = ({check_hi, b} == crc_acc);
					end
					if (!at_end) begin
						pos_in_block = DATA_W'(at + 1);
					end else begin
						r.block_verdict = VERDICT_DISCARD;
						pos_in_block = '0;
						link_phase = ST_WAIT;
						if (({1'b0, hdr_number} + {1'b0, hdr_complement}) != NUMBER_PAIR_SUM) begin
							r.reply_valid = 1'b1;
							r.reply_byte = CH_NAK;
							if (errors_seen != COUNT_MAX) errors_seen = errors_seen + 1'b1;
						end else if (hdr_number == last_committed) begin
							r.reply_valid = 1'b1;
							r.reply_byte = CH_ACK;
						end else if (hdr_number == last_committed + 8'd1) begin
							r.reply_valid = 1'b1;
							if (check_ok) begin
								r.reply_byte = CH_ACK;
								r.block_verdict = VERDICT_COMMIT;
								last_committed = last_committed + 8'd1;
							end else begin
								r.reply_byte = CH_NAK;
								if (errors_seen != COUNT_MAX) errors_seen = errors_seen + 1'b1;
							end
						end else begin
							r = abort_transfer(r);
						end
					end
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("reply %0d/%02h cancel %0d data %0d/%02h@%0d verdict %0d finished %0d",
			r.reply_valid, r.reply_byte, r.send_cancel, r.data_valid, r.data_byte,
			r.data_index, r.block_verdict, r.finished);
	endfunction

	always @(posedge clk or negedge arst_n) begin : sender
		result_t want;
		if (!arst_n) begin
			push <= 1'b0;
			func <= FUNC_BYTE;
			rx_byte <= '0;
		end else begin
			if (push && !full) begin
				want = predict_response(func, rx_byte);
				responses_due.push_back(want);
				items_sent++;
				if (func == FUNC_START) transfers++;
				if (want.block_verdict == VERDICT_COMMIT) commits++;
				if (want.block_verdict == VERDICT_DISCARD) discards++;
				endings[want.finished]++;
				void'(link_items.pop_front());
			end
			if (hold) begin
				push <= 1'b0;
			end else if (!push || !full) begin
				if (link_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					push <= 1'b1;
					func <= link_items[0].func;
					rx_byte <= link_items[0].b;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver_side
		result_t got, want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got = {reply_valid, reply_byte, send_cancel, data_valid, data_byte,
					data_index, block_verdict, finished};
				results_seen++;
				if (responses_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: response with none expected: %s", $time, describe(got));
					end
				end else begin
					want = responses_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch, expected %s", $time, describe(want));
							$display("%0t:           actual   %s", $time, describe(got));
						end
					end
				end
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d responses outstanding.",
				cycles, responses_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_item(input logic f, input logic [DATA_W-1:0] b);
		link_items.push_back({f, b});
		items_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (link_items.size() != 0 || push || responses_due.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_USE_CRC) begin
			crc_mode = value[0];
		end else begin
			err_limit = value;
		end
	endtask

	task automatic queue_block(input logic [DATA_W-1:0] num, input logic [DATA_W-1:0] cmp,
		output logic [DATA_W-1:0] sum_v, output logic [CRC_W-1:0] crc_v);
		int style;
		logic [DATA_W-1:0] b;
		style = $urandom_range(9);
		sum_v = '0;
		crc_v = '0;
		queue_item(FUNC_BYTE, CH_SOH);
		queue_item(FUNC_BYTE, num);
		queue_item(FUNC_BYTE, cmp);
		for (int i = 0; i < BLOCK_LEN; i++) begin
			if (style == 0) begin
				b = 8'h00;
			end else if (style == 1) begin
				b = 8'hFF;
			end else begin
				b = DATA_W'($urandom_range(255));
			end
			queue_item(FUNC_BYTE, b);
			sum_v = sum_v + b;
			crc_v = crc16_next(crc_v, b);
		end
	endtask

	task automatic queue_trailer(input logic crc, input logic [DATA_W-1:0] sum_v,
		input logic [CRC_W-1:0] crc_v, input logic spoil);
		logic [DATA_W-1:0] flip;
		logic [CRC_W-1:0] t;
		flip = spoil ? DATA_W'($urandom_range(1, 255)) : '0;
		if (crc) begin
			t = crc_v ^ ({8'h00, flip} << (8 * $urandom_range(1)));
			queue_item(FUNC_BYTE, t[CRC_W-1:DATA_W]);
			queue_item(FUNC_BYTE, t[DATA_W-1:0]);
		end else begin
			queue_item(FUNC_BYTE, sum_v ^ flip);
		end
	endtask

	task automatic queue_session(input logic crc);
		int blocks, kind;
		logic [DATA_W-1:0] last, num, cmp, b, sum_v;
		logic [CRC_W-1:0] crc_v;
		logic spoil, ended;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 4))
				queue_item(1'($urandom_range(1)), DATA_W'($urandom_range(255)));
		end
		queue_item(FUNC_START, DATA_W'($urandom_range(255)));
		last = '0;
		ended = 1'b0;
		blocks = $urandom_range(0, 2);
		for (int n = 0; n < blocks && !ended; n++) begin
			kind = $urandom_range(99);
			num = last + 8'd1;
			cmp = ~num;
			spoil = 1'b0;
			if (kind >= 60 && kind < 72) begin
				spoil = 1'b1;
			end else if (kind >= 72 && kind < 82) begin
				num = last;
				cmp = ~num;
			end else if (kind >= 82 && kind < 92) begin
				cmp = cmp ^ DATA_W'($urandom_range(1, 255));
				spoil = 1'($urandom_range(1));
			end else if (kind >= 92) begin
				num = last + 8'd2 + DATA_W'($urandom_range(253));
				cmp = ~num;
				ended = 1'b1;
			end
			queue_block(num, cmp, sum_v, crc_v);
			queue_trailer(crc, sum_v, crc_v, spoil);
			if (kind < 60) last = num;
		end
		if (!ended) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				queue_item(FUNC_BYTE, CH_EOT);
				repeat ($urandom_range(0, 2)) queue_item(FUNC_BYTE, DATA_W'($urandom_range(255)));
				queue_item(FUNC_BYTE, CH_EOT);
			end else if (kind < 70) begin
				queue_item(FUNC_BYTE, CH_CAN);
			end else if (kind < 82) begin
				do b = DATA_W'($urandom_range(255));
				while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
				queue_item(FUNC_BYTE, b);
			end else if (kind < 92) begin
				queue_item(FUNC_BYTE, CH_SOH);
				repeat ($urandom_range(0, 20)) queue_item(FUNC_BYTE, DATA_W'($urandom_range(255)));
			end
		end
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) queue_item(FUNC_BYTE, DATA_W'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(input int sender_idle, input int recv_stall, input logic crc,
		input logic [DATA_W-1:0] limit, input logic pause);
		int goal, half;
		wait_drained();
		idle_pct = sender_idle;
		stall_pct = recv_stall;
		write_reg(REG_USE_CRC, {7'($urandom_range(127)), crc});
		write_reg(REG_ERROR_LIMIT, limit);
		goal = items_queued + PHASE_ITEMS;
		while (items_queued < goal) queue_session(crc);
		if (pause) begin
			// Once half the queued items are sent, the sender holds back until every outstanding transaction has been answered.
			half = link_items.size() / 2;
			do @(negedge clk);
			while (link_items.size() > half);
			hold = 1'b1;
			do @(negedge clk);
			while (push || responses_due.size() != 0);
			hold = 1'b0;
		end
		wait_drained();
	endtask

	initial begin : stimulus
		logic [DATA_W-1:0] sum_v;
		logic [CRC_W-1:0] crc_v;
		int failures;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bytes before any start are ignored; the reset configuration answers a start with C.
		queue_item(FUNC_BYTE, CH_SOH);
		queue_item(FUNC_BYTE, 8'hFF);
		queue_item(FUNC_START, 8'h00);
		queue_item(FUNC_BYTE, CH_EOT);
		queue_item(FUNC_BYTE, 8'h00);
		queue_item(FUNC_BYTE, CH_SOH);
		queue_item(FUNC_BYTE, CH_EOT);
		queue_item(FUNC_BYTE, CH_CAN);
		queue_item(FUNC_START, 8'hFF);
		queue_item(FUNC_BYTE, CH_CAN);
		queue_item(FUNC_START, 8'h5A);
		queue_item(FUNC_BYTE, 8'hFF);
		queue_item(FUNC_START, 8'hA5);
		queue_item(FUNC_BYTE, CH_SOH);
		queue_item(FUNC_BYTE, 8'h01);
		queue_item(FUNC_START, 8'h00);
		queue_item(FUNC_BYTE, CH_EOT);
		queue_item(FUNC_BYTE, CH_EOT);
		wait_drained();

		// With a zero error limit a single failed block turns the next fatal error into a cancel.
		write_reg(REG_ERROR_LIMIT, 8'd0);
		queue_item(FUNC_START, 8'h00);
		queue_block(8'd1, 8'd254, sum_v, crc_v);
		queue_trailer(1'b1, sum_v, crc_v, 1'b1);
		queue_item(FUNC_BYTE, 8'h7E);

		// The check mode changes between the payload and the trailer of a block.
		queue_item(FUNC_START, 8'h00);
		queue_block(8'd1, 8'd254, sum_v, crc_v);
		wait_drained();
		write_reg(REG_USE_CRC, 8'd0);
		queue_trailer(1'b0, sum_v, crc_v, 1'b0);
		queue_item(FUNC_BYTE, CH_EOT);
		queue_item(FUNC_BYTE, CH_EOT);
		queue_item(FUNC_START, 8'h00);
		queue_item(FUNC_BYTE, CH_CAN);

		run_phase(0, 0, 1'b1, 8'd10, 1'b1);
		run_phase(75, 0, 1'b0, 8'd255, 1'b0);
		run_phase(0, 75, 1'b1, 8'd1, 1'b0);
		run_phase(17, 17, 1'b0, 8'd0, 1'b0);
		run_phase(0, 0, 1'($urandom_range(1)), DATA_W'($urandom_range(255)), 1'b0);
		wait_drained();
		repeat (8) @(posedge clk);

		failures = mismatches + responses_due.size();
		if (responses_due.size() != 0) begin
			$display("%0d expected responses never arrived.", responses_due.size());
		end
		$display("Sent %0d link bytes and starts in %0d transfers, checked %0d responses.",
			items_sent, transfers, results_seen);
		$display("Blocks committed %0d, discarded %0d; done %0d, cancelled %0d, %s %0d, %s %0d.",
			commits, discards, endings[FIN_DONE], endings[FIN_CANCELLED],
			"error limit", endings[FIN_EXCESS], "aborted", endings[FIN_UNKNOWN]);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
src/xbr_pkg.sv
src/xbr_fifo.sv
src/xbr_front.sv
src/xbr_engine.sv
src/xmodem_block_receiver.sv
bench/testbench.sv
